// ===== rtl/lokf_pkg.sv =====
`default_nettype none

package lokf_pkg;

  // Field and state widths
  localparam int POS_W      = 16;
  localparam int LEN_W      = 16;
  localparam int K_W        = 6;
  localparam int FLIP_LIMIT = 63;
  localparam int RING_DEPTH = FLIP_LIMIT + 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int MAX_LEN    = 65535;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [PADDR_W-3:0] {
    REG_MAX_FLIPS = 1'b0
  } lokf_reg_t;

  // Per-cycle control broadcast along the cell chain
  typedef struct packed {
    logic           shift;    // a zero was accepted: push its position
    logic           is_zero;  // current input bit is zero
    logic [K_W-1:0] flips;    // allowed zeros inside the window
  } lokf_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lokf_if.sv =====
`default_nettype none

interface lokf_in_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic last_of_sequence;

  modport source (output valid, output bit_value, output last_of_sequence, input ready);
  modport sink (input valid, input bit_value, input last_of_sequence, output ready);
endinterface

interface lokf_out_if import lokf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] best_length;
  logic [LEN_W-1:0] window_length;
  logic             overflow;
  logic             sequence_done;

  modport source (output valid, output best_length, output window_length,
                  output overflow, output sequence_done, input ready);
  modport sink (input valid, input best_length, input window_length,
                input overflow, input sequence_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/lokf_cell.sv =====
`default_nettype none

module lokf_cell import lokf_pkg::*; (
  input  wire logic             clk,
  input  wire lokf_ctl_t        ctl,
  input  wire logic [K_W-1:0]   cell_index,
  input  wire logic [POS_W-1:0] pos_in,
  output logic      [POS_W-1:0] pos_out,
  output logic      [POS_W-1:0] tap_out
);

  logic [POS_W-1:0] pos;
  logic             hit;

  // Take the neighbor's position whenever a zero enters the chain
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pos <= pos_in;
    end
  end

  // Pick this cell when it will hold the (k+1)-th most recent zero
  always_comb begin
    if (ctl.is_zero) begin
      hit = ({1'b0, cell_index} + (K_W+1)'(1)) == {1'b0, ctl.flips};
    end else begin
      hit = cell_index == ctl.flips;
    end
  end

  assign pos_out = pos;
  assign tap_out = hit ? pos : '0;

endmodule

`default_nettype wire

// ===== rtl/lokf_chain.sv =====
`default_nettype none

module lokf_chain import lokf_pkg::*; (
  input  wire logic             clk,
  input  wire lokf_ctl_t        ctl,
  input  wire logic [POS_W-1:0] pos_cur,
  output logic      [POS_W-1:0] tap_pos
);

  logic [POS_W-1:0] link [RING_DEPTH+1];
  logic [POS_W-1:0] taps [RING_DEPTH];
  logic [POS_W-1:0] tap_or;

  assign link[0] = pos_cur;

  // Row of position cells, newest zero at the head
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    lokf_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_index (K_W'(i)),
      .pos_in     (link[i]),
      .pos_out    (link[i+1]),
      .tap_out    (taps[i])
    );
  end

  // Merge the one-hot taps
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  // A zero with no allowed flips bounds the window at itself
  assign tap_pos = (ctl.is_zero && ctl.flips == '0) ? pos_cur : tap_or;

endmodule

`default_nettype wire

// ===== rtl/longest_ones_with_k_flips_unit.sv =====
`default_nettype none
// A result is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one bit per cycle unless out_ch stalls; a one-hot tap picks the (k+1)-th
//   zero from the 64-cell chain for one subtract and one compare in the same cycle.
// Reset (rst, synchronous): clears counters, best length, overflow and max_flips.
//   Cell contents are not cleared; they are read only once written in a sequence.

module longest_ones_with_k_flips_unit import lokf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  lokf_in_if.sink                 in_ch,
  lokf_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [K_W-1:0]   max_flips;
  logic [POS_W-1:0] position_count;
  logic [CNT_W-1:0] zeros_seen;
  logic [LEN_W-1:0] best_so_far;
  logic             overflow_flag;

  logic             out_valid;
  logic [LEN_W-1:0] out_best;
  logic [LEN_W-1:0] out_window;
  logic             out_overflow;
  logic             out_done;

  logic             accept;
  logic             saturated;
  logic [POS_W-1:0] pos_cur;
  logic [CNT_W-1:0] zeros_next;
  logic [POS_W-1:0] tap_pos;
  logic [POS_W:0]   start;
  logic [POS_W:0]   win;
  logic [LEN_W-1:0] best_next;
  lokf_ctl_t        ctl;
  lokf_reg_t        reg_sel;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = lokf_reg_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_flips <= '0;
    end else if (psel && penable && pwrite && reg_sel == REG_MAX_FLIPS) begin
      max_flips <= pwdata[K_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MAX_FLIPS) begin
      prdata = PDATA_W'(max_flips);
    end
  end

  // Handshake: the output register parts the two sides
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Position of this bit, held at the top once the sequence runs long
  assign saturated = position_count >= POS_W'(MAX_LEN);
  assign pos_cur   = saturated ? POS_W'(MAX_LEN - 1) : position_count;

  assign zeros_next = (!in_ch.bit_value && zeros_seen < CNT_W'(RING_DEPTH)) ?
                      zeros_seen + CNT_W'(1) : zeros_seen;

  assign ctl.shift   = accept && !in_ch.bit_value;
  assign ctl.is_zero = !in_ch.bit_value;
  assign ctl.flips   = max_flips;

  lokf_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .pos_cur (pos_cur),
    .tap_pos (tap_pos)
  );

  // Window starts past the (k+1)-th most recent zero, else at sequence start
  assign start     = (zeros_next > CNT_W'(max_flips)) ?
                     {1'b0, tap_pos} + (POS_W+1)'(1) : '0;
  assign win       = {1'b0, pos_cur} + (POS_W+1)'(1) - start;
  assign best_next = (win > {1'b0, best_so_far}) ? win[LEN_W-1:0] : best_so_far;

  // Sequence state: advance on each transaction, drop after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      zeros_seen     <= '0;
      best_so_far    <= '0;
      overflow_flag  <= 1'b0;
    end else if (accept) begin
      if (in_ch.last_of_sequence) begin
        position_count <= '0;
        zeros_seen     <= '0;
        best_so_far    <= '0;
        overflow_flag  <= 1'b0;
      end else begin
        if (!saturated) begin
          position_count <= position_count + POS_W'(1);
        end
        zeros_seen    <= zeros_next;
        best_so_far   <= best_next;
        overflow_flag <= overflow_flag || saturated;
      end
    end
  end

  // Output register: load on accept, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_best     <= best_next;
      out_window   <= win[LEN_W-1:0];
      out_overflow <= overflow_flag || saturated;
      out_done     <= in_ch.last_of_sequence;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.best_length   = out_best;
  assign out_ch.window_length = out_window;
  assign out_ch.overflow      = out_overflow;
  assign out_ch.sequence_done = out_done;

  // Checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.last_of_sequence |=>
      position_count == '0 && zeros_seen == '0 && best_so_far == '0 && !overflow_flag)
    else $error("sequence state not cleared after last bit");

  a_zeros_bounded: assert property (@(posedge clk) disable iff (rst)
    zeros_seen <= CNT_W'(RING_DEPTH))
    else $error("zero count above ring depth");

  a_window_le_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_window <= out_best)
    else $error("window length exceeds best length");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && overflow_flag && !in_ch.last_of_sequence |=> overflow_flag)
    else $error("overflow flag dropped inside a sequence");

endmodule

`default_nettype wire
